// ===== sv/chacha20_key_erasure_rng_core_defines.svh =====
// Assertion macros for the key-erasure random generator
`ifndef CHACHA20_KEY_ERASURE_RNG_CORE_DEFINES_SVH
`define CHACHA20_KEY_ERASURE_RNG_CORE_DEFINES_SVH
`ifndef SYNTH
`define CKERNG_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("ckerng assertion failed");
`define CKERNG_ASSERT_RST(lbl, expr) \
  lbl: assert property (@(posedge clk) (expr)) else $error("ckerng reset assertion failed");
`else
`define CKERNG_ASSERT(lbl, expr)
`define CKERNG_ASSERT_RST(lbl, expr)
`endif
`endif

// ===== sv/ckerng_pkg.sv =====
// Shared types and constants for the key-erasure random generator
`default_nettype none
package ckerng_pkg;
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam logic KIND_RESEED = 1'b0;
  localparam logic KIND_READ   = 1'b1;
  localparam int KEY_BYTES   = 32;

  typedef struct packed {
    logic       kind;
    logic [3:0] count;
  } ckerng_item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] blk;
    logic [3:0]  word;
  } ckerng_rctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ckerng_rsts_t;
endpackage
`default_nettype wire

// ===== sv/chacha20_key_erasure_rng_core.sv =====
// Top level of the ChaCha20 fast-key-erasure random byte generator
// Input channel: in_kind (reseed or read) and in_byte_count (0 to 8, larger saturates).
// Each input transfer yields exactly one output transfer on out_random_data, in order.
// A reseed loads the key from the four seed registers and empties the pool.
// A read returns its bytes little-endian, unused upper bytes zero.
// Configuration: cfg_index 0..3 selects a 64-bit seed word; other indices are dropped.
// A read passes each byte through a pool check state and a data state, then a result
// state; a reseed goes straight to the result state.
// A refill when the pool runs out builds each 64-byte block from a start step,
// 80 quarter-round steps and a done step in the shared round unit, then
// 16 memory word writes; its cost is shared by the reads that the pool serves.
// A two-entry queue takes new items while the back end works or a result waits.
// The back end starts an item only when the output register is empty, so a
// stalled receiver holds the queue, and then in_ready falls.
// Reset: queue empty, seed and key zero, pool marked used up so the first read refills.
`default_nettype none
`include "chacha20_key_erasure_rng_core_defines.svh"
module chacha20_key_erasure_rng_core #(
  parameter int POOL_BYTES     = 512,
  parameter int MAX_READ_BYTES = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_kind,
  input  wire  [3:0]  in_byte_count,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] out_random_data,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_index,
  input  wire  [63:0] cfg_data
);
  import ckerng_pkg::*;

  logic         item_valid, item_pop;
  ckerng_item_t item;

  assign cfg_ready = 1'b1;

  ckerng_front #(.MAX_READ_BYTES(MAX_READ_BYTES)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_byte_count (in_byte_count),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop)
  );

  ckerng_back #(.POOL_BYTES(POOL_BYTES)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .item_valid      (item_valid),
    .item            (item),
    .item_pop        (item_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_data (out_random_data)
  );

  `CKERNG_ASSERT(a_pop_needs_item, item_pop |-> item_valid)
  `CKERNG_ASSERT(a_pop_spaced, item_pop |=> !item_pop)
  `CKERNG_ASSERT(a_pop_out_free, item_pop |-> !out_valid)
  `CKERNG_ASSERT_RST(a_reset_no_out, !rst_n |=> !out_valid)
endmodule
`default_nettype wire

// ===== sv/ckerng_front.sv =====
// Front end: input queue that saturates the byte count
`default_nettype none
module ckerng_front #(
  parameter int MAX_READ_BYTES = 8
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire                        in_kind,
  input  wire  [3:0]                 in_byte_count,
  output logic                       item_valid,
  output ckerng_pkg::ckerng_item_t   item,
  input  wire                        item_pop
);
  import ckerng_pkg::*;

  ckerng_item_t q_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  ckerng_item_t in_item;
  logic         push;

  always_comb begin
    in_item.kind  = in_kind;
    in_item.count = (in_byte_count > 4'(MAX_READ_BYTES)) ? 4'(MAX_READ_BYTES) : in_byte_count;
  end

  assign in_ready   = (cnt_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (item_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(item_pop);
    end
  end
endmodule
`default_nettype wire

// ===== sv/ckerng_round.sv =====
// ChaCha20 block unit: one quarter-round step per cycle across four lanes
`default_nettype none
module ckerng_round (
  input  wire                       clk,
  input  wire                       rst_n,
  input  ckerng_pkg::ckerng_rctl_t  ctl,
  input  wire  [7:0][31:0]          key,
  output ckerng_pkg::ckerng_rsts_t  sts,
  output logic [31:0]               ks_word
);
  import ckerng_pkg::*;

  logic [31:0] x_r [16];
  logic [31:0] x_nxt [16];
  logic [4:0]  rnd_r;
  logic [1:0]  stp_r;
  logic        busy_r, done_r;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] init_word(input logic [3:0] w, input logic [7:0][31:0] k,
                                            input logic [31:0] b);
    logic [31:0] r;
    r = 32'd0;
    if (w == 4'd0) r = SIGMA0;
    else if (w == 4'd1) r = SIGMA1;
    else if (w == 4'd2) r = SIGMA2;
    else if (w == 4'd3) r = SIGMA3;
    else if (w < 4'd12) r = k[3'(w - 4'd4)];
    else if (w == 4'd12) r = b;
    return r;
  endfunction

  always_comb begin
    logic [3:0] ia, ib, ic, id;
    logic       dg;
    x_nxt = x_r;
    dg = rnd_r[0];
    for (int q = 0; q < 4; q++) begin
      ia = 4'(q);
      ib = {2'b01, 2'(q) + {1'b0, dg}};
      ic = {2'b10, 2'(q) + {dg, 1'b0}};
      id = {2'b11, 2'(q) + {dg, dg}};
      unique case (stp_r)
        2'd0: begin
          x_nxt[ia] = x_r[ia] + x_r[ib];
          x_nxt[id] = rotl(x_r[id] ^ (x_r[ia] + x_r[ib]), 16);
        end
        2'd1: begin
          x_nxt[ic] = x_r[ic] + x_r[id];
          x_nxt[ib] = rotl(x_r[ib] ^ (x_r[ic] + x_r[id]), 12);
        end
        2'd2: begin
          x_nxt[ia] = x_r[ia] + x_r[ib];
          x_nxt[id] = rotl(x_r[id] ^ (x_r[ia] + x_r[ib]), 8);
        end
        default: begin
          x_nxt[ic] = x_r[ic] + x_r[id];
          x_nxt[ib] = rotl(x_r[ib] ^ (x_r[ic] + x_r[id]), 7);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < 16; i++) x_r[i] <= init_word(4'(i), key, ctl.blk);
    end else if (busy_r) begin
      x_r <= x_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 5'd0;
      stp_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        rnd_r  <= 5'd0;
        stp_r  <= 2'd0;
      end else if (busy_r) begin
        stp_r <= stp_r + 2'd1;
        if (stp_r == 2'd3) begin
          rnd_r <= rnd_r + 5'd1;
          if (rnd_r == 5'd19) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign ks_word  = x_r[ctl.word] + init_word(ctl.word, key, ctl.blk);
endmodule
`default_nettype wire

// ===== sv/ckerng_back.sv =====
// Back end: seed registers, pool memory, refill and byte read sequencer
`default_nettype none
module ckerng_back #(
  parameter int POOL_BYTES = 512
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       cfg_valid,
  input  wire  [7:0]                cfg_index,
  input  wire  [63:0]               cfg_data,
  input  wire                       item_valid,
  input  ckerng_pkg::ckerng_item_t  item,
  output logic                      item_pop,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [63:0]               out_random_data
);
  import ckerng_pkg::*;

  localparam int NWORDS = (POOL_BYTES + 3) / 4;
  localparam int AW     = $clog2(NWORDS);
  localparam int NBLK   = (POOL_BYTES + 63) / 64;
  localparam int BW     = $clog2(NBLK);
  localparam int PW     = $clog2(POOL_BYTES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_DATA  = 3'd2;
  localparam logic [2:0] S_RFST  = 3'd3;
  localparam logic [2:0] S_RFRUN = 3'd4;
  localparam logic [2:0] S_RFWR  = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [63:0]      seed_r [4];
  logic [7:0][31:0] key_r, newkey_r;
  logic [31:0]      mem [NWORDS];
  logic [31:0]      rdata_r;
  logic [2:0]       st_r;
  logic [PW-1:0]    pos_r;
  logic [3:0]       cnt_r, idx_r;
  logic [63:0]      data_r;
  logic [BW-1:0]    blk_r;
  logic [3:0]       w_r;
  logic             ovalid_r;
  logic [63:0]      odata_r;
  ckerng_rctl_t     rctl;
  ckerng_rsts_t     rsts;
  logic [31:0]      ks_word;
  logic [BW+3:0]    wr_addr;
  logic [7:0]       rbyte;

  ckerng_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (rctl),
    .key     (key_r),
    .sts     (rsts),
    .ks_word (ks_word)
  );

  assign rctl.start = (st_r == S_RFST);
  assign rctl.blk   = 32'(blk_r);
  assign rctl.word  = w_r;
  assign wr_addr    = {blk_r, w_r};
  assign rbyte      = 8'(rdata_r >> {pos_r[1:0], 3'b000});
  assign item_pop   = (st_r == S_IDLE) && item_valid && !ovalid_r;

  always_ff @(posedge clk) begin
    if (st_r == S_RFWR && 32'(wr_addr) < NWORDS) mem[wr_addr[AW-1:0]] <= ks_word;
    if (st_r == S_CHK) rdata_r <= mem[pos_r[AW+1:2]];
  end

  always_ff @(posedge clk) begin
    if (st_r == S_RFWR && blk_r == '0 && w_r < 4'd8) newkey_r[w_r[2:0]] <= ks_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) seed_r[i] <= 64'd0;
    end else if (cfg_valid && cfg_index < 8'd4) begin
      seed_r[cfg_index[1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      key_r    <= '0;
      pos_r    <= PW'(POOL_BYTES);
      ovalid_r <= 1'b0;
      cnt_r    <= 4'd0;
      idx_r    <= 4'd0;
      data_r   <= 64'd0;
      blk_r    <= '0;
      w_r      <= 4'd0;
    end else begin
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (item_pop) begin
            data_r <= 64'd0;
            idx_r  <= 4'd0;
            cnt_r  <= item.count;
            if (item.kind == KIND_RESEED) begin
              for (int i = 0; i < 4; i++) begin
                key_r[2*i]   <= seed_r[i][31:0];
                key_r[2*i+1] <= seed_r[i][63:32];
              end
              pos_r <= PW'(POOL_BYTES);
              st_r  <= S_RESP;
            end else if (item.count == 4'd0) begin
              st_r <= S_RESP;
            end else begin
              st_r <= S_CHK;
            end
          end
        end
        S_CHK: begin
          if (pos_r >= PW'(POOL_BYTES)) begin
            blk_r <= '0;
            st_r  <= S_RFST;
          end else begin
            st_r <= S_DATA;
          end
        end
        S_DATA: begin
          data_r <= data_r | (64'(rbyte) << {idx_r[2:0], 3'b000});
          pos_r  <= pos_r + PW'(1);
          idx_r  <= idx_r + 4'd1;
          st_r   <= (idx_r + 4'd1 == cnt_r) ? S_RESP : S_CHK;
        end
        S_RFST: begin
          w_r  <= 4'd0;
          st_r <= S_RFRUN;
        end
        S_RFRUN: begin
          if (rsts.done) st_r <= S_RFWR;
        end
        S_RFWR: begin
          w_r <= w_r + 4'd1;
          if (w_r == 4'd15) begin
            if (32'(blk_r) == NBLK - 1) begin
              key_r <= newkey_r;
              pos_r <= PW'(KEY_BYTES);
              st_r  <= S_CHK;
            end else begin
              blk_r <= blk_r + BW'(1);
              st_r  <= S_RFST;
            end
          end
        end
        S_RESP: begin
          ovalid_r <= 1'b1;
          st_r     <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_RESP) odata_r <= data_r;
  end

  assign out_valid       = ovalid_r;
  assign out_random_data = odata_r;
endmodule
`default_nettype wire

// ===== verif/chacha20_key_erasure_rng_core_tb.sv =====
// Self-checking testbench for the ChaCha20 key-erasure random byte generator core
`timescale 1ns / 1ps
module chacha20_key_erasure_rng_core_tb;
  import ckerng_pkg::*;

  localparam int POOL_SIZE = 512;
  localparam int READ_MAX  = 8;
  localparam int SEED_REGS = 4;
  localparam logic [7:0] IDX_SEED0 = 8'd0;
  localparam logic [7:0] IDX_SEED3 = 8'd3;
  localparam logic [7:0] IDX_BOGUS = 8'd200;
  localparam longint CYCLE_LIMIT = 64'd3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = KIND_READ;
  logic [3:0]  in_byte_count = 4'd1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_random_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'd0;
  logic [63:0] cfg_data = 64'd0;

  chacha20_key_erasure_rng_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_byte_count(in_byte_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_random_data(out_random_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  logic [63:0] seed_copy [SEED_REGS];
  logic [7:0]  pool_bytes [POOL_SIZE];
  int          next_byte;
  logic [63:0] expected_bytes [$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          refills = 0;
  longint      cycles = 0;

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic qround(ref logic [31:0] x [16], input int a, input int b,
                        input int c, input int d);
    x[a] = x[a] + x[b]; x[d] = rotl(x[d] ^ x[a], 16);
    x[c] = x[c] + x[d]; x[b] = rotl(x[b] ^ x[c], 12);
    x[a] = x[a] + x[b]; x[d] = rotl(x[d] ^ x[a], 8);
    x[c] = x[c] + x[d]; x[b] = rotl(x[b] ^ x[c], 7);
  endtask

  task automatic regenerate_pool();
    logic [31:0] key [8];
    logic [31:0] init [16];
    logic [31:0] x [16];
    logic [31:0] w;
    int nblk;
    nblk = (POOL_SIZE + 63) / 64;
    for (int i = 0; i < 8; i++)
      key[i] = {pool_bytes[4*i+3], pool_bytes[4*i+2], pool_bytes[4*i+1], pool_bytes[4*i]};
    for (int b = 0; b < nblk; b++) begin
      init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
      for (int i = 0; i < 8; i++) init[4+i] = key[i];
      init[12] = b; init[13] = 0; init[14] = 0; init[15] = 0;
      x = init;
      for (int r = 0; r < 10; r++) begin
        qround(x, 0, 4, 8, 12); qround(x, 1, 5, 9, 13);
        qround(x, 2, 6, 10, 14); qround(x, 3, 7, 11, 15);
        qround(x, 0, 5, 10, 15); qround(x, 1, 6, 11, 12);
        qround(x, 2, 7, 8, 13); qround(x, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) begin
        w = x[i] + init[i];
        for (int k = 0; k < 4; k++)
          if (b*64 + 4*i + k < POOL_SIZE) pool_bytes[b*64 + 4*i + k] = w[8*k +: 8];
      end
    end
    next_byte = KEY_BYTES;
    refills++;
  endtask

  task automatic predict_item(input logic kind, input logic [3:0] count);
    logic [63:0] data;
    int n;
    data = 64'd0;
    if (kind == KIND_RESEED) begin
      for (int i = 0; i < KEY_BYTES; i++) pool_bytes[i] = seed_copy[i/8][8*(i%8) +: 8];
      next_byte = POOL_SIZE;
    end else begin
      n = (count > READ_MAX) ? READ_MAX : count;
      for (int i = 0; i < n; i++) begin
        if (next_byte >= POOL_SIZE) regenerate_pool();
        data[8*i +: 8] = pool_bytes[next_byte];
        next_byte++;
      end
    end
    expected_bytes.push_back(data);
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("chacha20_key_erasure_rng_core_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_bytes.size() == 0)
          report_mismatch("result with nothing expected");
        else begin
          logic [63:0] exp_data;
          exp_data = expected_bytes.pop_front();
          if (out_random_data !== exp_data)
            report_mismatch($sformatf("random_data %h, expected %h", out_random_data, exp_data));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic kind, input logic [3:0] count);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_byte_count <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(kind, count);
    items_sent++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < SEED_REGS) seed_copy[idx[1:0]] = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_seed(input logic [63:0] w0, input logic [63:0] w1,
                           input logic [63:0] w2, input logic [63:0] w3);
    write_reg(IDX_SEED0, w0);
    write_reg(8'd1, w1);
    write_reg(8'd2, w2);
    write_reg(IDX_SEED3, w3);
  endtask

  task automatic random_traffic(input int n);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 5) send_item(KIND_RESEED, 4'($urandom));
      else if (roll < 15) send_item(KIND_READ, 4'($urandom));
      else send_item(KIND_READ, 4'($urandom_range(READ_MAX, 1)));
    end
  endtask

  task automatic test_zero_key_directed();
    send_item(KIND_READ, 4'd8);
    send_item(KIND_READ, 4'd1);
    send_item(KIND_READ, 4'd0);
    send_item(KIND_READ, 4'd15);
    send_item(KIND_READ, 4'd9);
    for (int c = 1; c <= 8; c++) send_item(KIND_READ, 4'(c));
    send_item(KIND_RESEED, 4'd0);
    send_item(KIND_READ, 4'd8);
    drain();
  endtask

  task automatic test_seed_extremes();
    load_seed(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(IDX_BOGUS, 64'h0123_4567_89AB_CDEF);
    write_reg(8'hFF, 64'hDEAD_BEEF_0000_0001);
    send_item(KIND_RESEED, 4'd8);
    for (int i = 0; i < 62; i++) send_item(KIND_READ, 4'd8);
    send_item(KIND_READ, 4'd7);
    send_item(KIND_READ, 4'd8);
    drain();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int n);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    load_seed({$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    send_item(KIND_RESEED, 4'($urandom));
    random_traffic(n);
    drain();
  endtask

  initial begin
    for (int i = 0; i < SEED_REGS; i++) seed_copy[i] = 64'd0;
    for (int i = 0; i < POOL_SIZE; i++) pool_bytes[i] = 8'd0;
    next_byte = POOL_SIZE;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_key_directed();
    test_seed_extremes();
    test_random_phase(0, 0, 110);
    test_random_phase(86, 0, 80);
    test_random_phase(0, 86, 80);
    test_random_phase(34, 34, 110);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_seed(64'd0, 64'd0, 64'd0, 64'd0);
    send_item(KIND_RESEED, 4'd1);
    send_item(KIND_READ, 4'd8);
    drain();
    $display("%0d items sent, %0d results checked, %0d pool refills predicted",
             items_sent, results_seen, refills);
    $display("covered reseeds, reads of 0 to 15 bytes, seed extremes, unmapped registers");
    if (mismatches == 0 && expected_bytes.size() == 0)
      $display("chacha20_key_erasure_rng_core_tb OK");
    else
      $display("chacha20_key_erasure_rng_core_tb NOT OK");
    $finish;
  end
endmodule

// ===== chacha20_key_erasure_rng_core.f =====
+incdir+sv
sv/ckerng_pkg.sv
sv/ckerng_front.sv
sv/ckerng_round.sv
sv/ckerng_back.sv
sv/chacha20_key_erasure_rng_core.sv
verif/chacha20_key_erasure_rng_core_tb.sv
